/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rdsa_pkg.sv */
// Shared types and constants for the digit-serial radix arithmetic block
package rdsa_pkg;

  localparam int DIG_W     = 6;
  localparam int MAX_RADIX = 36;
  localparam logic [DIG_W-1:0] RADIX_RST = DIG_W'(10);

  // widest dividend: a*b + carry with digits below MAX_RADIX
  localparam int DVD_W = $clog2((MAX_RADIX - 1) * (MAX_RADIX - 1) + 2**DIG_W);
  localparam int CNT_W = $clog2(DVD_W);

  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // take the input word
    logic prep;     // load divider from the captured operands
    logic load_v;   // divide: reload divider with rem*radix + a
    logic step;     // one restoring division step
    logic finish;   // write output register, update running carry
  } dp_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;     // no division needed (error or borrow-free subtract)
    logic is_div;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/rdsa_ctrl.sv */
// Sequencer for the digit-serial arithmetic datapath
`include "assert_macros.svh"

module rdsa_ctrl
  import rdsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_DIV  = 5'b00100,
    S_MID  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pass_r, pass_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.capture = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      S_LOAD: begin
        pass_nxt = 1'b0;
        if (stat.skip) begin
          state_nxt = S_FIN;
        end else begin
          ctrl.prep = 1'b1;
          cnt_nxt   = CNT_W'(DVD_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        ctrl.step = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = (stat.is_div && !pass_r) ? S_MID : S_FIN;
        end
      end
      S_MID: begin
        // first pass gave carry mod divisor; now the quotient digit
        ctrl.load_v = 1'b1;
        pass_nxt    = 1'b1;
        cnt_nxt     = CNT_W'(DVD_W - 1);
        state_nxt   = S_DIV;
      end
      S_FIN: begin
        if (stat.out_free) begin
          ctrl.finish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
    end
  end

  `ASSERT_NXT(a_accept_load, in_tvalid && in_tready, state_r == S_LOAD, "accept must go to LOAD")
  `ASSERT_NXT(a_div_second, (state_r == S_DIV) && (cnt_r == '0) && stat.is_div && !pass_r, state_r == S_MID, "divide must take a second pass")
  `ASSERT_IMP(a_fin_only, ctrl.finish, stat.out_free, "finish with output register busy")

endmodule

/* rtl/rdsa_dp.sv */
// Datapath: operands, running carry, restoring divider and output register
`include "assert_macros.svh"

module rdsa_dp
  import rdsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [DIG_W-1:0]       cfg_wr_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  dp_ctrl_t               ctrl,
  output dp_stat_t               stat
);

  logic [DIG_W-1:0] radix_r, carry_r, carry_nxt;
  op_t              op_r;
  logic [DIG_W-1:0] a_r, b_r;
  logic             last_r, err_r;

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DIG_W-1:0] dsr_r, dsr_nxt;
  logic [DIG_W-1:0] rem_r, rem_nxt;

  logic [DIG_W-1:0] odig_r, ocarry_r;
  logic             olast_r, oerr_r, out_valid_r;

  op_t              in_op;
  logic [DIG_W-1:0] in_a, in_b;
  logic             in_err;

  logic [DIG_W:0]   need;
  logic             sub_direct;
  logic [DVD_W-1:0] prep_dvd;
  logic [DIG_W:0]   trial;
  logic             ge;
  logic [DIG_W-1:0] quo6, dig, nc;
  logic [2*DIG_W-1:0] prod;

  // input word: cmd, digit_a, digit_b from bit 0 up
  assign in_op = op_t'(in_tdata[OP_W-1:0]);
  assign in_a  = in_tdata[OP_W+DIG_W-1:OP_W];
  assign in_b  = in_tdata[OP_W+2*DIG_W-1:OP_W+DIG_W];

  assign in_err = (radix_r < DIG_W'(2)) || (radix_r > DIG_W'(MAX_RADIX)) ||
                  (in_a >= radix_r) || (in_b >= radix_r) ||
                  ((in_op == OP_DIV) && (in_b == '0));

  assign need       = {1'b0, b_r} + {1'b0, carry_r};
  assign sub_direct = {1'b0, a_r} >= need;

  always_comb begin
    prod     = '0;
    prep_dvd = '0;
    case (op_r)
      OP_ADD: prep_dvd = DVD_W'({1'b0, a_r}) + DVD_W'({1'b0, b_r}) + DVD_W'(carry_r);
      // borrow k = (need - a - 1) / r + 1, digit = r - 1 - remainder
      OP_SUB: prep_dvd = DVD_W'(need - {1'b0, a_r} - 1'b1);
      OP_MUL: begin
        prod     = a_r * b_r;
        prep_dvd = DVD_W'(prod) + DVD_W'(carry_r);
      end
      OP_DIV: prep_dvd = DVD_W'(carry_r);
      default: prep_dvd = '0;
    endcase
  end

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    rem_nxt = rem_r;
    if (ctrl.prep) begin
      dvd_nxt = prep_dvd;
      dsr_nxt = (op_r == OP_DIV) ? b_r : radix_r;
      rem_nxt = '0;
    end else if (ctrl.load_v) begin
      dvd_nxt = DVD_W'(rem_r) * DVD_W'(radix_r) + DVD_W'(a_r);
      rem_nxt = '0;
    end else if (ctrl.step) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      rem_nxt = ge ? DIG_W'(trial - {1'b0, dsr_r}) : trial[DIG_W-1:0];
    end
  end

  assign quo6 = dvd_r[DIG_W-1:0];

  always_comb begin
    dig = '0;
    nc  = carry_r;
    if (!err_r) begin
      case (op_r)
        OP_ADD, OP_MUL: begin
          dig = rem_r;
          nc  = quo6;
        end
        OP_SUB: begin
          if (sub_direct) begin
            dig = DIG_W'({1'b0, a_r} - need);
            nc  = '0;
          end else begin
            dig = radix_r - 1'b1 - rem_r;
            nc  = quo6 + 1'b1;
          end
        end
        OP_DIV: begin
          dig = quo6;
          nc  = rem_r;
        end
        default: begin
          dig = '0;
          nc  = carry_r;
        end
      endcase
    end
  end

  assign carry_nxt = last_r ? '0 : nc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RST;
      carry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
      if (ctrl.finish) begin
        carry_r     <= carry_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      op_r   <= in_op;
      a_r    <= in_a;
      b_r    <= in_b;
      last_r <= in_tlast;
      err_r  <= in_err;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    if (ctrl.finish) begin
      odig_r   <= dig;
      ocarry_r <= (last_r && !err_r) ? nc : '0;
      olast_r  <= last_r;
      oerr_r   <= err_r;
    end
  end

  assign stat.skip     = err_r || ((op_r == OP_SUB) && sub_direct);
  assign stat.is_div   = (op_r == OP_DIV);
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*DIG_W){1'b0}}, ocarry_r, odig_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

  `ASSERT_NXT(a_rem_bound, ctrl.step, rem_r < dsr_r, "remainder not below divisor")
  `ASSERT_NXT(a_err_zero, ctrl.finish && err_r, (odig_r == '0) && (ocarry_r == '0) && oerr_r, "rejected word must give zero digits")
  `ASSERT_NXT(a_fin_valid, ctrl.finish, out_valid_r, "finish must fill output register")

endmodule

/* rtl/radix_digit_serial_arithmetic.sv */
// Top level: digit-serial add, subtract, multiply and divide in radix 2..36
//
//  channel | ports              | tdata (bit 0 up)        | side bands
//  in      | in_tvalid/tready   | cmd, digit_a, digit_b   | tlast = last_digit
//  out     | out_tvalid/tready  | digit_out, carry_out    | tlast = last, tuser = error
//  cfg     | cfg_wr_en          | cfg_wr_data = radix     | -
//
// Add, subtract with borrow and multiply run one 11-step restoring division by the
// radix; divide runs two division passes through the same divider; rejected words
// and borrow-free subtracts skip the divider.
// Reset: radix 10, running carry 0, output empty.
// The output register lets a finished word wait while the next input word is taken;
// the sequencer only stalls at the end of a word if that register is still full.
module radix_digit_serial_arithmetic
  import rdsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [DIG_W-1:0]       cfg_wr_data,   // radix
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // cmd[1:0], digit_a[7:2], digit_b[13:8]
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,     // digit_out[5:0], carry_out[11:6]
  output logic                   out_tlast,
  output logic                   out_tuser      // error
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  rdsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  rdsa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .ctrl        (ctrl),
    .stat        (stat)
  );

endmodule
